// ----- hw/rtl/programmable_window_address_router_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the programmable window address router
// Shared concurrent assertion forms used by the router's checker.
// ---------------------------------------------------------------------------
`ifndef PROGRAMMABLE_WINDOW_ADDRESS_ROUTER_TOP_MACROS_SVH
`define PROGRAMMABLE_WINDOW_ADDRESS_ROUTER_TOP_MACROS_SVH

// The expression must never hold outside reset.
`define PWAR_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("router check failed: forbidden condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define PWAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("router check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define PWAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("router check failed: next-cycle implication");

`endif

// ----- hw/rtl/pwar_pkg.sv -----
// ---------------------------------------------------------------------------
// Programmable window address router package
// Field widths, operation and status codes, and the sequencer state type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwar_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned WIDTH_W = 3;
  localparam int unsigned STAT_W  = 2;

  // Remainder steps of the shared subtractor, one address bit per cycle.
  localparam int unsigned DIV_CNT_W = $clog2(ADDR_W);

  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_REMAP    = 2'd1;
  localparam logic [OP_W-1:0] OP_ACCESS   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_SLOT = 2'd2;

  localparam logic [WIDTH_W-1:0] WIDTH_BYTE = 3'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_WORD = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FIX,
    ST_RESP
  } state_e;

endpackage

// ----- hw/rtl/programmable_window_address_router_top.sv -----
// ---------------------------------------------------------------------------
// Programmable window address router
// Keeps a table of device windows and routes bus accesses to a device window
// or to memory, with register and remap operations on the table.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  in        slave      in_valid_i / in_ready_o  operation, address, slot,
//                                                device_size, is_write,
//                                                width_bytes, write_data
//  out       master     out_valid_o / out_ready_i status, to_device,
//                                                device_slot, local_address,
//                                                out_write, out_width, out_data
//
// Register, unknown, table-full and bad-slot operations offer their result in
// the cycle after acceptance. A bus access examines the registered windows one
// at a time through the single window table read port. A remap passes through
// the divide and fix states, the division skipped for a window of size zero:
// the shared subtractor develops the remainder one address bit per cycle.
// Reset clears the device count and the sequencer; the window table is not
// cleared, as only registered slots are ever read. The block takes one
// transfer at a time: in_ready_o is low from acceptance until the result
// transfer completes, and a stalled result simply holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module programmable_window_address_router_top
  import pwar_pkg::*;
#(
  parameter int unsigned NUM_DEVICES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [ADDR_W-1:0]   device_size_i,
  input  logic                is_write_i,
  input  logic [WIDTH_W-1:0]  width_bytes_i,
  input  logic [ADDR_W-1:0]   write_data_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STAT_W-1:0]   status_o,
  output logic                to_device_o,
  output logic [SLOT_W-1:0]   device_slot_o,
  output logic [ADDR_W-1:0]   local_address_o,
  output logic                out_write_o,
  output logic [WIDTH_W-1:0]  out_width_o,
  output logic [ADDR_W-1:0]   out_data_o
);

  // Index of a table slot, and a count that can also hold NUM_DEVICES.
  localparam int unsigned IdxW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int unsigned CntW = $clog2(NUM_DEVICES + 1);
  localparam int unsigned CmpW = (CntW > SLOT_W) ? CntW : SLOT_W;

  // Sequencer state and working registers.
  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [ADDR_W-1:0]     rem_q, rem_d;
  logic [ADDR_W-1:0]     dvd_q, dvd_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;

  // Result register, held until the output transfer completes.
  logic [STAT_W-1:0]     res_status_q, res_status_d;
  logic                  res_dev_q, res_dev_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic [ADDR_W-1:0]     res_local_q, res_local_d;
  logic                  res_wr_q, res_wr_d;
  logic [WIDTH_W-1:0]    res_width_q, res_width_d;
  logic [ADDR_W-1:0]     res_data_q, res_data_d;

  // Window table: one write port, one registered read port.
  logic [ADDR_W-1:0]     base_mem [NUM_DEVICES];
  logic [ADDR_W-1:0]     size_mem [NUM_DEVICES];
  logic [ADDR_W-1:0]     base_rd_q;
  logic [ADDR_W-1:0]     size_rd_q;
  logic                  reg_we;
  logic                  base_we;
  logic [IdxW-1:0]       wr_idx;

  // The one shared subtractor, with a borrow bit beyond its 33-bit operands.
  logic [ADDR_W:0]       sub_a;
  logic [ADDR_W:0]       sub_b;
  logic [ADDR_W+1:0]     sub_y;
  logic                  sub_borrow;

  logic                  win_hit;
  logic                  scan_last;
  logic [WIDTH_W-1:0]    acc_width;
  logic [ADDR_W-1:0]     acc_data;

  // Operand selection: window offset while scanning, a trial subtraction of
  // the window size while dividing, and the final round-down when fixing.
  always_comb begin
    unique case (state_q)
      ST_SCAN: begin
        sub_a = {1'b0, addr_q};
        sub_b = {1'b0, base_rd_q};
      end
      ST_DIV: begin
        sub_a = {rem_q, dvd_q[ADDR_W-1]};
        sub_b = {1'b0, size_rd_q};
      end
      default: begin
        sub_a = {1'b0, addr_q};
        sub_b = {1'b0, rem_q};
      end
    endcase
  end

  assign sub_y      = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_y[ADDR_W+1];

  // A window at base zero is unmapped. Given the address is at or above the
  // base, it lies below base + size exactly when the offset is below size,
  // so the end never has to be formed and cannot wrap.
  assign win_hit   = (base_rd_q != '0) && !sub_borrow && (sub_y[ADDR_W-1:0] < size_rd_q);
  assign scan_last = ((CntW'(idx_q) + CntW'(1)) == count_q);

  // Forwarded access attributes: anything but a byte access is a word access,
  // and a read forwards no data.
  assign acc_width = (width_bytes_i == WIDTH_BYTE) ? WIDTH_BYTE : WIDTH_WORD;
  always_comb begin
    if (!is_write_i) begin
      acc_data = '0;
    end else if (width_bytes_i == WIDTH_BYTE) begin
      acc_data = {{(ADDR_W-8){1'b0}}, write_data_i[7:0]};
    end else begin
      acc_data = write_data_i;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    addr_d       = addr_q;
    rem_d        = rem_q;
    dvd_d        = dvd_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_dev_d    = res_dev_q;
    res_slot_d   = res_slot_q;
    res_local_d  = res_local_q;
    res_wr_d     = res_wr_q;
    res_width_d  = res_width_q;
    res_data_d   = res_data_q;
    reg_we       = 1'b0;
    base_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          addr_d       = address_i;
          rem_d        = '0;
          dvd_d        = address_i;
          cnt_d        = '0;
          res_status_d = STATUS_OK;
          res_dev_d    = 1'b0;
          res_slot_d   = '0;
          res_local_d  = '0;
          res_wr_d     = 1'b0;
          res_width_d  = '0;
          res_data_d   = '0;
          state_d      = ST_RESP;
          unique case (operation_i)
            OP_REGISTER: begin
              if (count_q >= CntW'(NUM_DEVICES)) begin
                res_status_d = STATUS_FULL;
              end else begin
                reg_we     = 1'b1;
                res_slot_d = SLOT_W'(count_q);
                count_d    = count_q + CntW'(1);
              end
            end
            OP_REMAP: begin
              if (CmpW'(slot_i) < CmpW'(count_q)) begin
                idx_d   = IdxW'(slot_i);
                state_d = ST_DIV;
              end else begin
                res_status_d = STATUS_BAD_SLOT;
              end
            end
            OP_ACCESS: begin
              // Memory route is the default; a window hit overrides it.
              res_local_d = address_i;
              res_wr_d    = is_write_i;
              res_width_d = acc_width;
              res_data_d  = acc_data;
              if (count_q != '0) begin
                idx_d   = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (win_hit) begin
          res_dev_d   = 1'b1;
          res_slot_d  = SLOT_W'(idx_q);
          res_local_d = sub_y[ADDR_W-1:0];
          state_d     = ST_RESP;
        end else if (scan_last) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      ST_DIV: begin
        if (size_rd_q == '0) begin
          // Zero size keeps the new base: the remainder stays zero.
          state_d = ST_FIX;
        end else begin
          rem_d = sub_borrow ? sub_a[ADDR_W-1:0] : sub_y[ADDR_W-1:0];
          dvd_d = {dvd_q[ADDR_W-2:0], 1'b0};
          cnt_d = cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(ADDR_W - 1)) begin
            state_d = ST_FIX;
          end
        end
      end

      ST_FIX: begin
        base_we = 1'b1;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign wr_idx = (state_q == ST_IDLE) ? count_q[IdxW-1:0] : idx_q;

  // Window table. The read address follows the next slot index, so the data
  // for the current slot is ready in every scan or divide cycle.
  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      base_mem[wr_idx] <= '0;
      size_mem[wr_idx] <= device_size_i;
    end else if (base_we) begin
      base_mem[wr_idx] <= sub_y[ADDR_W-1:0];
    end
    base_rd_q <= base_mem[idx_d];
    size_rd_q <= size_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    addr_q       <= addr_d;
    rem_q        <= rem_d;
    dvd_q        <= dvd_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_dev_q    <= res_dev_d;
    res_slot_q   <= res_slot_d;
    res_local_q  <= res_local_d;
    res_wr_q     <= res_wr_d;
    res_width_q  <= res_width_d;
    res_data_q   <= res_data_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = (state_q == ST_RESP);
  assign status_o        = res_status_q;
  assign to_device_o     = res_dev_q;
  assign device_slot_o   = res_slot_q;
  assign local_address_o = res_local_q;
  assign out_write_o     = res_wr_q;
  assign out_width_o     = res_width_q;
  assign out_data_o      = res_data_q;

endmodule

// ----- hw/rtl/pwar_checker.sv -----
// ---------------------------------------------------------------------------
// Programmable window address router checker
// Port-level assertions on the router's transfer sequencing and results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "programmable_window_address_router_top_macros.svh"

module pwar_checker
  import pwar_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STAT_W-1:0]   status_i,
  input logic                to_device_i,
  input logic [WIDTH_W-1:0]  out_width_i
);

  `PWAR_ASSERT_NEVER(a_one_item_at_a_time, clk_i, rst_ni, in_ready_i && out_valid_i)
  `PWAR_ASSERT_NEXT(a_busy_after_input, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `PWAR_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `PWAR_ASSERT_IMPL(a_device_route_ok, clk_i, rst_ni, out_valid_i && to_device_i, (status_i == STATUS_OK) && (out_width_i == WIDTH_BYTE || out_width_i == WIDTH_WORD))

endmodule

bind programmable_window_address_router_top pwar_checker u_pwar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_i    (status_o),
  .to_device_i (to_device_o),
  .out_width_i (out_width_o)
);
